// ----- design/atsp_pkg.sv -----
// Shared types, constants and the frame size table for the ATS parser.
`default_nettype none

package atsp_pkg;

  // Largest number of historical bytes that are kept
  localparam logic [3:0] HIST_MAX = 4'd15;

  // Reset values of the parsed fields
  localparam logic [3:0] FSCI_DEFAULT = 4'd2;
  localparam logic [3:0] FWI_DEFAULT  = 4'd4;

  // Pending interface byte flags
  localparam int unsigned PEND_TA = 0;
  localparam int unsigned PEND_TB = 1;
  localparam int unsigned PEND_TC = 2;

  // Largest FSCI with its own frame size
  localparam logic [3:0] FSCI_TOP = 4'd8;

  typedef enum logic [1:0] {
    ST_BUSY = 2'd0,
    ST_OK   = 2'd1,
    ST_ERR  = 2'd2
  } atsp_status_t;

  // One input item
  typedef struct packed {
    logic [7:0] ats_byte;
    logic       last_byte;
  } atsp_item_t;

  // Fields parsed from T0, TA, TB, TC
  typedef struct packed {
    logic [3:0] fsci;
    logic [3:0] fwi;
    logic [3:0] sfgi;
    logic [6:0] rate;
    logic       cid;
    logic       nad;
  } atsp_fields_t;

  localparam atsp_fields_t FIELDS_RESET = '{
    fsci: FSCI_DEFAULT, fwi: FWI_DEFAULT, sfgi: 4'd0, rate: 7'd0, cid: 1'b0, nad: 1'b0
  };

  // One result item
  typedef struct packed {
    logic         historical_valid;
    logic [7:0]   historical_byte;
    atsp_status_t status;
    logic [3:0]   frame_size_index;
    logic [8:0]   frame_size_bytes;
    logic [3:0]   wait_time_index;
    logic [3:0]   guard_time_index;
    logic [6:0]   rate_flags;
    logic         cid_capable;
    logic         nad_capable;
    logic [3:0]   card_id;
    logic [3:0]   historical_count;
  } atsp_result_t;

  // Card frame size in bytes for an FSCI, indexes above eight give 256
  function automatic logic [8:0] frame_size(input logic [3:0] fsci);
    logic [8:0] fs;
    case (fsci)
      4'd0:    fs = 9'd16;
      4'd1:    fs = 9'd24;
      4'd2:    fs = 9'd32;
      4'd3:    fs = 9'd40;
      4'd4:    fs = 9'd48;
      4'd5:    fs = 9'd64;
      4'd6:    fs = 9'd96;
      4'd7:    fs = 9'd128;
      default: fs = 9'd256;
    endcase
    return fs;
  endfunction

endpackage

`default_nettype wire

// ----- design/atsp_in_reg.sv -----
// Input register stage of the ATS parser.
`default_nettype none

module atsp_in_reg
  import atsp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,
  input  wire logic       in_tlast,
  input  wire logic       advance,    // next stage takes the held item this cycle
  output logic            s1_valid,
  output atsp_item_t      s1_item
);

  logic       valid_r, valid_nxt;
  atsp_item_t item_r;

  // Take a new item when empty or when the held one moves on
  assign in_tready = !valid_r || advance;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tready) begin
      valid_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.ats_byte  <= in_tdata;
      item_r.last_byte <= in_tlast;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

`default_nettype wire

// ----- design/atsp_parse.sv -----
// Parse state and per-byte update logic of the ATS parser.
`default_nettype none

module atsp_parse
  import atsp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,           // item moves to the result register
  input  wire atsp_item_t item,
  input  wire logic [3:0] requested_cid,
  output atsp_result_t    result
);

  logic [7:0]   cnt_r, cnt_nxt;
  logic [7:0]   len_r, len_nxt;
  logic [2:0]   pend_r, pend_nxt;
  logic         err_r, err_nxt;
  atsp_fields_t fld_r, fld_nxt;
  logic [3:0]   kept_r, kept_nxt;
  logic         hist_valid;
  logic [7:0]   hist_byte;
  logic         frame_bad;
  logic [7:0]   b;

  assign b = item.ats_byte;

  // Next parse state for the byte at hand
  always_comb begin
    cnt_nxt    = cnt_r;
    len_nxt    = len_r;
    pend_nxt   = pend_r;
    err_nxt    = err_r;
    fld_nxt    = fld_r;
    kept_nxt   = kept_r;
    hist_valid = 1'b0;
    hist_byte  = 8'd0;
    if (cnt_r == 8'd0) begin
      len_nxt = b;
    end else if (err_r) begin
      // nothing is parsed after an error
    end else if (cnt_r == 8'd1) begin
      // T0
      if (b[7]) begin
        err_nxt = 1'b1;
      end else begin
        fld_nxt.fsci = b[3:0];
        pend_nxt     = b[6:4];
      end
    end else if (pend_r[PEND_TA]) begin
      pend_nxt[PEND_TA] = 1'b0;
      if (b[3]) begin
        err_nxt = 1'b1;
      end else begin
        fld_nxt.rate = fld_r.rate | {b[7:4], b[2:0]};
      end
    end else if (pend_r[PEND_TB]) begin
      pend_nxt[PEND_TB] = 1'b0;
      fld_nxt.sfgi = b[3:0];
      fld_nxt.fwi  = b[7:4];
    end else if (pend_r[PEND_TC]) begin
      pend_nxt[PEND_TC] = 1'b0;
      if (|b[7:2]) begin
        err_nxt = 1'b1;
      end else begin
        fld_nxt.nad = b[0];
        fld_nxt.cid = b[1];
      end
    end else if (kept_r < HIST_MAX) begin
      // historical byte
      kept_nxt   = kept_r + 4'd1;
      hist_valid = 1'b1;
      hist_byte  = b;
    end
    if (cnt_r != 8'hFF) begin
      cnt_nxt = cnt_r + 8'd1;
    end
  end

  // Final check at the last byte
  assign frame_bad = err_nxt || (len_nxt == 8'd0) || (len_nxt != cnt_nxt) ||
                     (pend_nxt != 3'd0);

  // Result for this byte
  always_comb begin
    result.historical_valid = hist_valid;
    result.historical_byte  = hist_byte;
    if (!item.last_byte) begin
      result.status = ST_BUSY;
    end else if (frame_bad) begin
      result.status = ST_ERR;
    end else begin
      result.status = ST_OK;
    end
    result.frame_size_index = fld_nxt.fsci;
    result.frame_size_bytes = frame_size(fld_nxt.fsci);
    result.wait_time_index  = fld_nxt.fwi;
    result.guard_time_index = fld_nxt.sfgi;
    result.rate_flags       = fld_nxt.rate;
    result.cid_capable      = fld_nxt.cid;
    result.nad_capable      = fld_nxt.nad;
    result.card_id          = fld_nxt.cid ? requested_cid : 4'd0;
    result.historical_count = kept_nxt;
  end

  // State registers, cleared after the last byte of an answer
  always_ff @(posedge clk) begin
    if (!rst_n || (step && item.last_byte)) begin
      cnt_r  <= 8'd0;
      len_r  <= 8'd0;
      pend_r <= 3'd0;
      err_r  <= 1'b0;
      fld_r  <= FIELDS_RESET;
      kept_r <= 4'd0;
    end else if (step) begin
      cnt_r  <= cnt_nxt;
      len_r  <= len_nxt;
      pend_r <= pend_nxt;
      err_r  <= err_nxt;
      fld_r  <= fld_nxt;
      kept_r <= kept_nxt;
    end
  end

  // The last byte restarts the parse
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    step && item.last_byte |=> cnt_r == 8'd0 && pend_r == 3'd0 && kept_r == 4'd0)
    else $error("parse state not cleared after last byte");

  // Interface bytes are only announced by T0
  a_pend_after_t0: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 3'd0 |-> cnt_r >= 8'd2)
    else $error("interface bytes pending before T0");

  // A historical byte is never taken while interface bytes are due
  a_hist_order: assert property (@(posedge clk) disable iff (!rst_n)
    hist_valid |-> pend_r == 3'd0 && cnt_r >= 8'd2 && !err_r)
    else $error("historical byte taken out of order");

  // Kept count moves only with a kept byte
  a_kept_step: assert property (@(posedge clk) disable iff (!rst_n)
    step && !item.last_byte |=> kept_r == $past(kept_r) + {3'd0, $past(hist_valid)})
    else $error("historical count out of step");

endmodule

`default_nettype wire

// ----- design/atsp_out_reg.sv -----
// Result register stage of the ATS parser.
`default_nettype none

module atsp_out_reg
  import atsp_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         load,         // a result is offered this cycle
  input  wire atsp_result_t result,
  output logic              advance,      // register can take a result
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [47:0]       out_tdata,
  output logic              out_tuser
);

  logic         valid_r, valid_nxt;
  atsp_result_t res_r;

  assign advance = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (advance) begin
      valid_nxt = load;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (advance && load) begin
      res_r <= result;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tuser  = res_r.historical_valid;
  assign out_tdata  = {res_r.historical_count, res_r.card_id, res_r.nad_capable,
                       res_r.cid_capable, res_r.rate_flags, res_r.guard_time_index,
                       res_r.wait_time_index, res_r.frame_size_bytes,
                       res_r.frame_size_index, res_r.status, res_r.historical_byte};

endmodule

`default_nettype wire

// ----- design/ats_answer_parser.sv -----
// Top level of the ISO 14443-4 answer-to-select parser.
//
//  channel  dir  handshake              payload
//  in_      in   in_tvalid/in_tready    in_tdata ats_byte, in_tlast last_byte
//  out_     out  out_tvalid/out_tready  out_tdata parsed fields, out_tuser hist valid
//  cfg_     in   cfg_wr_en              cfg_wr_data requested_cid
//
// One item per cycle sustained while the output is not stalled; each byte's result
// passes from the input register through the parse logic into the result register,
// where it is held until out_tready takes it.
// The parse state advances as an item moves into the result register.
// Reset clears both stages, the parse state and requested_cid.
// A stalled output holds its result; one more item waits in the input register.
`default_nettype none

module ats_answer_parser
  import atsp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,     // [7:0] ats_byte
  input  wire logic        in_tlast,     // last_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,    // [7:0] historical_byte, [9:8] status,
                                         // [13:10] frame_size_index,
                                         // [22:14] frame_size_bytes,
                                         // [26:23] wait_time_index,
                                         // [30:27] guard_time_index,
                                         // [37:31] rate_flags, [38] cid_capable,
                                         // [39] nad_capable, [43:40] card_id,
                                         // [47:44] historical_count
  output logic             out_tuser,    // [0] historical_valid
  input  wire logic        cfg_wr_en,
  input  wire logic [3:0]  cfg_wr_data   // requested_cid
);

  logic         advance;
  logic         s1_valid;
  atsp_item_t   s1_item;
  atsp_result_t result;
  logic [3:0]   req_cid_r;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_cid_r <= 4'd0;
    end else if (cfg_wr_en) begin
      req_cid_r <= cfg_wr_data;
    end
  end

  atsp_in_reg u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .advance   (advance),
    .s1_valid  (s1_valid),
    .s1_item   (s1_item)
  );

  atsp_parse u_parse (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (s1_valid && advance),
    .item          (s1_item),
    .requested_cid (req_cid_r),
    .result        (result)
  );

  atsp_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (s1_valid),
    .result     (result),
    .advance    (advance),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

// ----- test/ats_answer_parser_tb.sv -----
// Self-checking testbench for the ATS parser: directed table, random frames, handshake stress.
`timescale 1ns / 100ps

module ats_answer_parser_tb
  import atsp_pkg::*;
();

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 60;

  // Kinds of generated ATS frames
  typedef enum int {
    FR_GOOD, FR_T0_RSVD, FR_TA_RSVD, FR_TC_RSVD, FR_CUT, FR_TL_ZERO, FR_TL_RAND, FR_NOISE
  } frame_kind_t;

  // Directed row: item plus optional typed-in status and kept count
  typedef struct {
    logic [7:0]   b;
    logic         l;
    bit           pin;
    atsp_status_t st;
    logic [3:0]   hc;
  } ats_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;
  logic        out_tuser;
  logic        cfg_wr_en;
  logic [3:0]  cfg_wr_data;

  ats_answer_parser u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Parser shadow state
  logic [7:0]   ats_cnt;
  logic [7:0]   ats_tl;
  logic [2:0]   ats_pend;
  logic         ats_bad;
  atsp_fields_t pf;
  logic [3:0]   ats_kept;
  logic [3:0]   req_cid;
  logic [8:0]   fsize_tab [0:8] = '{9'd16, 9'd24, 9'd32, 9'd40, 9'd48,
                                    9'd64, 9'd96, 9'd128, 9'd256};

  atsp_result_t expect_q[$];
  atsp_result_t want;
  ats_row_t     dir_rows[$];
  logic [7:0]   frm[$];
  int           errors = 0;
  int           cyc = 0;
  int           send_idle = 0;
  int           recv_stall = 0;
  bit           hold_req = 1'b0;

  function automatic void clear_ats();
    ats_cnt  = 8'd0;
    ats_tl   = 8'd0;
    ats_pend = 3'd0;
    ats_bad  = 1'b0;
    pf       = FIELDS_RESET;
    ats_kept = 4'd0;
  endfunction

  // Advance the shadow parser by one byte and return the result it gives
  function automatic atsp_result_t parse_ats_byte(input logic [7:0] b, input logic l);
    atsp_result_t r;
    r = '0;
    if (ats_cnt == 8'd0) begin
      ats_tl = b;
    end else if (ats_bad) begin
      // nothing parsed after a format error
    end else if (ats_cnt == 8'd1) begin
      if (b[7]) begin
        ats_bad = 1'b1;
      end else begin
        pf.fsci  = b[3:0];
        ats_pend = b[6:4];
      end
    end else if (ats_pend[PEND_TA]) begin
      ats_pend[PEND_TA] = 1'b0;
      if (b[3]) ats_bad = 1'b1;
      else pf.rate = pf.rate | {b[7:4], b[2:0]};
    end else if (ats_pend[PEND_TB]) begin
      ats_pend[PEND_TB] = 1'b0;
      pf.sfgi = b[3:0];
      pf.fwi  = b[7:4];
    end else if (ats_pend[PEND_TC]) begin
      ats_pend[PEND_TC] = 1'b0;
      if (b[7:2] != 6'd0) begin
        ats_bad = 1'b1;
      end else begin
        pf.nad = b[0];
        pf.cid = b[1];
      end
    end else if (ats_kept < HIST_MAX) begin
      ats_kept++;
      r.historical_valid = 1'b1;
      r.historical_byte  = b;
    end

    if (ats_cnt != 8'hFF) ats_cnt++;

    r.status = ST_BUSY;
    if (l) begin
      r.status = (ats_bad || ats_tl == 8'd0 || ats_tl != ats_cnt || ats_pend != 3'd0) ?
                 ST_ERR : ST_OK;
    end
    r.frame_size_index = pf.fsci;
    r.frame_size_bytes = fsize_tab[(pf.fsci > FSCI_TOP) ? FSCI_TOP : pf.fsci];
    r.wait_time_index  = pf.fwi;
    r.guard_time_index = pf.sfgi;
    r.rate_flags       = pf.rate;
    r.cid_capable      = pf.cid;
    r.nad_capable      = pf.nad;
    r.card_id          = pf.cid ? req_cid : 4'd0;
    r.historical_count = ats_kept;
    if (l) clear_ats();
    return r;
  endfunction

  function automatic void cmp_field(input string name, input int unsigned exp_v,
                                    input int unsigned got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      errors++;
    end
  endfunction

  function automatic void add_row(input logic [7:0] b, input logic l, input bit pin,
                                  input atsp_status_t st, input logic [3:0] hc);
    ats_row_t row;
    row.b   = b;
    row.l   = l;
    row.pin = pin;
    row.st  = st;
    row.hc  = hc;
    dir_rows.push_back(row);
  endfunction

  // Offer one item with random sender gaps, then record what it should give
  task automatic send_item(input logic [7:0] b, input logic l, input bit pin,
                           input atsp_status_t st, input logic [3:0] hc);
    atsp_result_t r;
    while ($urandom_range(0, 99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= l;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = parse_ats_byte(b, l);
    if (pin) begin
      r.status           = st;
      r.historical_count = hc;
    end
    expect_q.push_back(r);
  endtask

  task automatic send_frame();
    foreach (frm[i]) send_item(frm[i], i == frm.size() - 1, 1'b0, ST_BUSY, 4'd0);
  endtask

  // Stop offering and wait until every result is back
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expect_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_cid(input logic [3:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    req_cid = v;
  endtask

  // Build one ATS in frm: mostly well formed, sometimes broken or pure noise
  task automatic make_frame();
    frame_kind_t fk;
    logic [2:0]  ifl;
    int          nh;
    frm.delete();
    fk = ($urandom_range(0, 99) < 80) ? FR_GOOD : frame_kind_t'($urandom_range(1, 7));
    if (fk == FR_NOISE) begin
      repeat ($urandom_range(1, 10)) frm.push_back(8'($urandom));
      return;
    end
    ifl = 3'($urandom);
    if (fk == FR_TA_RSVD) ifl[PEND_TA] = 1'b1;
    if (fk == FR_TC_RSVD) ifl[PEND_TC] = 1'b1;
    if (fk == FR_CUT && ifl == 3'd0) ifl = 3'b111;
    frm.push_back(8'd0);
    frm.push_back({fk == FR_T0_RSVD, ifl, 4'($urandom)});
    // a cut frame ends right after T0 with its interface bytes missing
    if (fk != FR_CUT) begin
      if (ifl[PEND_TA])
        frm.push_back(fk == FR_TA_RSVD ? (8'($urandom) | 8'h08) : (8'($urandom) & 8'hF7));
      if (ifl[PEND_TB]) frm.push_back(8'($urandom));
      if (ifl[PEND_TC])
        frm.push_back(fk == FR_TC_RSVD ? {6'($urandom_range(1, 63)), 2'($urandom)} :
                                         8'($urandom_range(0, 3)));
      nh = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 22) : $urandom_range(0, 6);
      repeat (nh) frm.push_back(8'($urandom));
    end
    case (fk)
      FR_TL_ZERO: frm[0] = 8'd0;
      FR_TL_RAND: frm[0] = 8'($urandom);
      default:    frm[0] = 8'(frm.size());
    endcase
  endtask

  task automatic run_phase(input int s_idle, input int r_stall, input logic [3:0] cid,
                           input bit pressure, input int n_items);
    int sent;
    drain();
    send_idle  = s_idle;
    recv_stall = r_stall;
    write_cid(cid);
    sent = 0;
    if (pressure) begin
      // receiver holds off while a long ATS streams in; count saturates at TL 255
      hold_req = 1'b1;
      frm.delete();
      frm.push_back(8'hFF);
      frm.push_back(8'h00);
      repeat (258) frm.push_back(8'($urandom));
      send_frame();
    end
    while (sent < n_items) begin
      make_frame();
      send_frame();
      sent += frm.size();
    end
  endtask

  // Receiver: random stalls, or a long hold-off on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= recv_stall);
      end
    end
  end

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expect_q.size() == 0) begin
        $error("result item with nothing expected");
        errors++;
      end else begin
        want = expect_q.pop_front();
        cmp_field("historical_valid", want.historical_valid, out_tuser);
        cmp_field("historical_byte", want.historical_byte, out_tdata[7:0]);
        cmp_field("status", want.status, out_tdata[9:8]);
        cmp_field("frame_size_index", want.frame_size_index, out_tdata[13:10]);
        cmp_field("frame_size_bytes", want.frame_size_bytes, out_tdata[22:14]);
        cmp_field("wait_time_index", want.wait_time_index, out_tdata[26:23]);
        cmp_field("guard_time_index", want.guard_time_index, out_tdata[30:27]);
        cmp_field("rate_flags", want.rate_flags, out_tdata[37:31]);
        cmp_field("cid_capable", want.cid_capable, out_tdata[38]);
        cmp_field("nad_capable", want.nad_capable, out_tdata[39]);
        cmp_field("card_id", want.card_id, out_tdata[43:40]);
        cmp_field("historical_count", want.historical_count, out_tdata[47:44]);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    in_tvalid   = 1'b0;
    in_tdata    = 8'd0;
    in_tlast    = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = 4'd0;
    rst_n       = 1'b0;
    req_cid     = 4'd0;
    clear_ats();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_cid(4'd14);

    // TL only, right after reset: defaults
    add_row(8'h01, 1'b1, 1'b1, ST_OK, 4'd0);
    // TL of zero
    add_row(8'h00, 1'b1, 1'b1, ST_ERR, 4'd0);
    // T0 with its reserved top bit set
    add_row(8'h02, 1'b0, 1'b1, ST_BUSY, 4'd0);
    add_row(8'h80, 1'b1, 1'b1, ST_ERR, 4'd0);
    // TA, TB, TC all at their extremes, FSCI 15, two historical bytes
    add_row(8'h07, 1'b0, 1'b0, ST_BUSY, 4'd0);
    add_row(8'h7F, 1'b0, 1'b0, ST_BUSY, 4'd0);
    add_row(8'hF7, 1'b0, 1'b0, ST_BUSY, 4'd0);
    add_row(8'hFF, 1'b0, 1'b0, ST_BUSY, 4'd0);
    add_row(8'h03, 1'b0, 1'b0, ST_BUSY, 4'd0);
    add_row(8'hFF, 1'b0, 1'b0, ST_BUSY, 4'd0);
    add_row(8'h00, 1'b1, 1'b1, ST_OK, 4'd2);
    // TA with its reserved bit set
    add_row(8'h03, 1'b0, 1'b0, ST_BUSY, 4'd0);
    add_row(8'h10, 1'b0, 1'b0, ST_BUSY, 4'd0);
    add_row(8'h08, 1'b1, 1'b1, ST_ERR, 4'd0);
    // TC with reserved bits set
    add_row(8'h03, 1'b0, 1'b0, ST_BUSY, 4'd0);
    add_row(8'h40, 1'b0, 1'b0, ST_BUSY, 4'd0);
    add_row(8'hFC, 1'b1, 1'b1, ST_ERR, 4'd0);
    // TA, TB, TC announced but missing
    add_row(8'h02, 1'b0, 1'b0, ST_BUSY, 4'd0);
    add_row(8'h70, 1'b1, 1'b1, ST_ERR, 4'd0);
    // TL longer than the bytes sent
    add_row(8'h03, 1'b0, 1'b0, ST_BUSY, 4'd0);
    add_row(8'h00, 1'b1, 1'b1, ST_ERR, 4'd0);
    foreach (dir_rows[i])
      send_item(dir_rows[i].b, dir_rows[i].l, dir_rows[i].pin, dir_rows[i].st, dir_rows[i].hc);

    run_phase(0, 0, 4'd0, 1'b1, 40);
    run_phase(49, 0, 4'd15, 1'b0, 40);
    run_phase(0, 49, 4'($urandom), 1'b0, 40);
    run_phase(21, 21, 4'd7, 1'b0, 40);

    drain();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/atsp_pkg.sv
design/atsp_in_reg.sv
design/atsp_parse.sv
design/atsp_out_reg.sv
design/ats_answer_parser.sv
test/ats_answer_parser_tb.sv
